@@ design/gfau_pkg.sv @@
// Shared types and constants for the GF(2^7) arithmetic unit.
// Used by the top level and by the inversion and multiply units.
package gfau_pkg;

   localparam int unsigned ELEM_W = 7;

   // Field polynomial x^7 + x + 1, with the x^7 term included.
   localparam logic [7:0] POLY_FULL = 8'h83;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_INV = 3'd3;
   localparam logic [2:0] OP_DIV = 3'd4;

   typedef struct packed {
      logic [2:0]        op;
      logic [ELEM_W-1:0] operand_a;
      logic [ELEM_W-1:0] operand_b;
   } gfau_req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] field_result;
      logic              no_inverse;
   } gfau_rsp_type;

   typedef struct packed {
      logic              load;
      logic              step;
      logic [ELEM_W-1:0] operand;
   } gfau_inv_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [ELEM_W-1:0] inverse;
   } gfau_inv_stat_type;

   typedef struct packed {
      logic              load;
      logic              step;
      logic [ELEM_W-1:0] multiplicand;
      logic [ELEM_W-1:0] multiplier;
   } gfau_mul_ctrl_type;

   typedef struct packed {
      logic              last;
      logic [ELEM_W-1:0] product;
   } gfau_mul_stat_type;

endpackage

@@ design/gfau_inv.sv @@
// Extended Euclid inversion unit: one polynomial reduction step per cycle while step is high.
// Depends on gfau_pkg for the control and status types.
module gfau_inv (
   input  logic                       clock,
   input  gfau_pkg::gfau_inv_ctrl_type ctrl,
   output gfau_pkg::gfau_inv_stat_type stat
);
   import gfau_pkg::*;

   logic [7:0]  u_ff, u_in, v_ff, v_in;
   logic [13:0] g1_ff, g1_in, g2_ff, g2_in;
   logic [2:0]  deg_u, deg_v, shift;
   logic [7:0]  su, sv;
   logic [13:0] sg1, sg2;

   function automatic logic [2:0] degree(input logic [7:0] p);
      logic [2:0] d;
      d = '0;
      for (int i = 0; i < 8; i++) begin
         if (p[i]) begin
            d = 3'(i);
         end
      end
      return d;
   endfunction

   function automatic logic [ELEM_W-1:0] reduce(input logic [13:0] p);
      logic [13:0] r;
      r = p;
      for (int i = 13; i >= 7; i--) begin
         if (r[i]) begin
            r = r ^ (14'(POLY_FULL) << (i - 7));
         end
      end
      return r[ELEM_W-1:0];
   endfunction

   always_comb begin
      deg_u = degree(u_ff);
      deg_v = degree(v_ff);
      // Keep the higher-degree polynomial in u so the step cancels its top term.
      if (deg_u < deg_v) begin
         su    = v_ff;
         sv    = u_ff;
         sg1   = g2_ff;
         sg2   = g1_ff;
         shift = deg_v - deg_u;
      end else begin
         su    = u_ff;
         sv    = v_ff;
         sg1   = g1_ff;
         sg2   = g2_ff;
         shift = deg_u - deg_v;
      end
      u_in  = u_ff;
      v_in  = v_ff;
      g1_in = g1_ff;
      g2_in = g2_ff;
      if (ctrl.load) begin
         u_in  = {1'b0, ctrl.operand};
         v_in  = POLY_FULL;
         g1_in = 14'd1;
         g2_in = '0;
      end else if (ctrl.step) begin
         u_in  = su ^ (sv << shift);
         v_in  = sv;
         g1_in = sg1 ^ (sg2 << shift);
         g2_in = sg2;
      end
   end

   always_ff @(posedge clock) begin
      u_ff  <= u_in;
      v_ff  <= v_in;
      g1_ff <= g1_in;
      g2_ff <= g2_in;
   end

   assign stat.done    = (u_ff == 8'd1);
   assign stat.inverse = reduce(g1_ff);

endmodule

@@ design/gfau_mul.sv @@
// Bit-serial GF(2^7) multiplier: one multiplier bit per cycle while step is high.
// Depends on gfau_pkg for the control and status types.
module gfau_mul (
   input  logic                       clock,
   input  gfau_pkg::gfau_mul_ctrl_type ctrl,
   output gfau_pkg::gfau_mul_stat_type stat
);
   import gfau_pkg::*;

   logic [ELEM_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in, mplier_ff, mplier_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [ELEM_W-1:0] acc_next;
   logic [7:0]        mcand_shift;

   always_comb begin
      acc_next    = mplier_ff[0] ? (acc_ff ^ mcand_ff) : acc_ff;
      mcand_shift = {mcand_ff, 1'b0};
      if (mcand_shift[7]) begin
         mcand_shift = mcand_shift ^ POLY_FULL;
      end
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      if (ctrl.load) begin
         acc_in    = '0;
         mcand_in  = ctrl.multiplicand;
         mplier_in = ctrl.multiplier;
         cnt_in    = '0;
      end else if (ctrl.step) begin
         acc_in    = acc_next;
         mcand_in  = mcand_shift[ELEM_W-1:0];
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign stat.last    = (cnt_ff == 3'(ELEM_W - 1));
   assign stat.product = acc_next;

endmodule

@@ design/gf128_arithmetic_unit.sv @@
// Top level of the GF(2^7) arithmetic unit: sequencer and result register.
// Depends on gfau_pkg, gfau_inv and gfau_mul.
//
// A word is taken when start is high and busy is low; busy then stays high
// until its result has been shown. The result appears on rsp_data for exactly
// one cycle with rsp_valid high, and the receiver must capture it then, since
// it cannot hold the unit off. Add, subtract, unused op codes and the
// zero-element cases go straight to the done state; multiply runs the
// serial multiplier, inverse runs the Euclid unit until it is done, and
// divide runs the Euclid unit on b and then the multiplier on a times that
// inverse. The Euclid unit does one reduction step per cycle and the serial
// multiplier takes one operand bit per cycle.
module gf128_arithmetic_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  gfau_pkg::gfau_req_type req_data,
   output logic                  rsp_valid,
   output gfau_pkg::gfau_rsp_type rsp_data
);
   import gfau_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_INV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [ELEM_W-1:0] a_ff, a_in, res_ff, res_in;
   logic              flag_ff, flag_in;

   gfau_inv_ctrl_type inv_ctrl;
   gfau_inv_stat_type inv_stat;
   gfau_mul_ctrl_type mul_ctrl;
   gfau_mul_stat_type mul_stat;

   gfau_inv u_inv (
      .clock (clock),
      .ctrl  (inv_ctrl),
      .stat  (inv_stat)
   );

   gfau_mul u_mul (
      .clock (clock),
      .ctrl  (mul_ctrl),
      .stat  (mul_stat)
   );

   assign busy = reset | (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      res_in   = res_ff;
      flag_in  = flag_ff;
      inv_ctrl = '0;
      mul_ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               op_in   = req_data.op;
               a_in    = req_data.operand_a;
               res_in  = '0;
               flag_in = 1'b0;
               unique case (req_data.op)
                  OP_ADD, OP_SUB: begin
                     res_in   = req_data.operand_a ^ req_data.operand_b;
                     state_in = ST_DONE;
                  end
                  OP_MUL: begin
                     mul_ctrl.load         = 1'b1;
                     mul_ctrl.multiplicand = req_data.operand_a;
                     mul_ctrl.multiplier   = req_data.operand_b;
                     state_in              = ST_MUL;
                  end
                  OP_INV: begin
                     if (req_data.operand_a == '0) begin
                        flag_in  = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        inv_ctrl.load    = 1'b1;
                        inv_ctrl.operand = req_data.operand_a;
                        state_in         = ST_INV;
                     end
                  end
                  OP_DIV: begin
                     if (req_data.operand_b == '0) begin
                        flag_in  = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        inv_ctrl.load    = 1'b1;
                        inv_ctrl.operand = req_data.operand_b;
                        state_in         = ST_INV;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_INV: begin
            if (inv_stat.done) begin
               if (op_ff == OP_INV) begin
                  res_in   = inv_stat.inverse;
                  state_in = ST_DONE;
               end else begin
                  // Divide: reuse the multiplier on a times the inverse of b.
                  mul_ctrl.load         = 1'b1;
                  mul_ctrl.multiplicand = a_ff;
                  mul_ctrl.multiplier   = inv_stat.inverse;
                  state_in              = ST_MUL;
               end
            end else begin
               inv_ctrl.step = 1'b1;
            end
         end
         ST_MUL: begin
            mul_ctrl.step = 1'b1;
            if (mul_stat.last) begin
               res_in   = mul_stat.product;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      a_ff    <= a_in;
      res_ff  <= res_in;
      flag_ff <= flag_in;
   end

   assign rsp_valid             = (state_ff == ST_DONE);
   assign rsp_data.field_result = res_ff;
   assign rsp_data.no_inverse   = flag_ff;

endmodule

@@ design/gfau_checker.sv @@
// Port-level checks for the GF(2^7) arithmetic unit, bound to its top level.
// Depends on gfau_pkg for the word types and op codes.
module gfau_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input gfau_pkg::gfau_req_type req_data,
   input logic                  rsp_valid,
   input gfau_pkg::gfau_rsp_type rsp_data
);
   import gfau_pkg::*;

   // A result strobe lasts one cycle and frees the unit right after it.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle or unit still busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("unit not busy after accepting a word");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while unit reports idle");

   // Add and subtract answer in the next cycle with the XOR of the operands.
   a_xor_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_ADD || req_data.op == OP_SUB)
      |=> rsp_valid && !rsp_data.no_inverse
          && rsp_data.field_result == $past(req_data.operand_a ^ req_data.operand_b))
      else $error("wrong add or subtract result");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_inverse |-> rsp_data.field_result == '0)
      else $error("no-inverse result carries a nonzero element");

endmodule

bind gf128_arithmetic_unit gfau_checker u_gfau_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
